// ----- rtl/first_fit_slot_allocator_macros.svh -----
// Assertion macros for the first-fit slot allocator checker
`ifndef FIRST_FIT_SLOT_ALLOCATOR_MACROS_SVH
`define FIRST_FIT_SLOT_ALLOCATOR_MACROS_SVH

// Same-cycle implication, masked while reset is asserted
`define FFSA_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("first_fit_slot_allocator: assertion failed");

// Next-cycle implication, masked while reset is asserted
`define FFSA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("first_fit_slot_allocator: assertion failed");

// Same-cycle implication that is also checked through reset
`define FFSA_ASSERT_ALWAYS(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |-> (cons)) \
        else $error("first_fit_slot_allocator: assertion failed");

`endif

// ----- rtl/ffsa_pkg.sv -----
package ffsa_pkg;

    // Default segment size in slots
    localparam int SLOTS_DEF = 256;

    // Field widths
    localparam int FUNC_W     = 1;
    localparam int SIZE_W     = 9;
    localparam int ADDR_W     = 16;
    localparam int USABLE_W   = 9;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    // Register reset values
    localparam logic [ADDR_W-1:0]   BASE_RST   = 16'h0000;
    localparam logic [USABLE_W-1:0] USABLE_RST = 9'd255;

    // Request codes
    localparam logic [FUNC_W-1:0] FUNC_FIRST_FIT = 1'b0;
    localparam logic [FUNC_W-1:0] FUNC_FIXED     = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_BASE   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_USABLE = 1'b1;

    // Controller to datapath commands
    typedef struct packed {
        logic clr;
        logic load;
        logic scan_start;
        logic scan;
        logic mark;
        logic resp_ok;
        logic resp_fail;
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic clr_last;
        logic pre_ok;
        logic found;
        logic fail;
        logic mark_last;
        logic out_free;
    } t_status;

endpackage

// ----- rtl/ffsa_ctrl.sv -----
module ffsa_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  ffsa_pkg::t_status i_status,
    output ffsa_pkg::t_cmd   o_cmd,
    output logic             o_in_stall
);
    import ffsa_pkg::*;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_CHECK,
        S_SCAN,
        S_MARK,
        S_RESP
    } t_state;

    t_state r_state, n_state;
    logic   r_ok, n_ok;
    t_cmd   cmd;

    // Next state and commands
    always_comb begin
        n_state = r_state;
        n_ok    = r_ok;
        cmd     = '0;
        case (r_state)
            S_CLEAR: begin
                cmd.clr = 1'b1;
                if (i_status.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    cmd.load = 1'b1;
                    n_state  = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_status.pre_ok) begin
                    cmd.scan_start = 1'b1;
                    n_state        = S_SCAN;
                end else begin
                    n_ok    = 1'b0;
                    n_state = S_RESP;
                end
            end
            S_SCAN: begin
                cmd.scan = 1'b1;
                if (i_status.found) begin
                    n_state = S_MARK;
                end else if (i_status.fail) begin
                    n_ok    = 1'b0;
                    n_state = S_RESP;
                end
            end
            S_MARK: begin
                cmd.mark = 1'b1;
                if (i_status.mark_last) begin
                    n_ok    = 1'b1;
                    n_state = S_RESP;
                end
            end
            S_RESP: begin
                if (i_status.out_free) begin
                    cmd.resp_ok   = r_ok;
                    cmd.resp_fail = !r_ok;
                    n_state       = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Hold state and outcome
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_ok    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ok    <= n_ok;
        end
    end

    assign o_cmd      = cmd;
    assign o_in_stall = (r_state != S_IDLE);

endmodule

// ----- rtl/ffsa_dp.sv -----
module ffsa_dp #(
    parameter int SLOTS = ffsa_pkg::SLOTS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [ffsa_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [ffsa_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic [ffsa_pkg::FUNC_W-1:0]     i_func,
    input  logic [ffsa_pkg::SIZE_W-1:0]     i_size,
    input  logic [ffsa_pkg::ADDR_W-1:0]     i_address,
    input  logic                            i_out_stall,
    input  ffsa_pkg::t_cmd                  i_cmd,
    output ffsa_pkg::t_status               o_status,
    output logic                            o_out_valid,
    output logic                            o_out_ok,
    output logic [ffsa_pkg::ADDR_W-1:0]     o_out_granted_address
);
    import ffsa_pkg::*;

    // Slot index width and a width that also holds the slot count
    localparam int SW = $clog2(SLOTS);
    localparam int LW = (SW + 1 > USABLE_W) ? SW + 1 : USABLE_W;
    localparam int EW = ADDR_W + 1;
    localparam logic [LW-1:0] SLOTS_L = LW'(SLOTS);

    // Configuration
    logic [ADDR_W-1:0]   r_base;
    logic [USABLE_W-1:0] r_usable;

    // Request
    logic [FUNC_W-1:0] r_func;
    logic [SIZE_W-1:0] r_size;
    logic [EW-1:0]     r_off;

    // Scan
    logic [LW-1:0]     r_rd;
    logic [LW-1:0]     r_ck;
    logic              r_ck_valid;
    logic [SIZE_W-1:0] r_run;
    logic              r_rdata;

    // Marking and clearing
    logic [SW-1:0]     r_clr;
    logic [SW-1:0]     r_start;
    logic [SW-1:0]     r_mark;
    logic [SIZE_W-1:0] r_left;

    // Result word
    logic              r_out_valid;
    logic              r_out_ok;
    logic [ADDR_W-1:0] r_out_addr;

    // Slot flags
    logic mem [SLOTS];

    logic [LW-1:0]     limit;
    logic [EW-1:0]     fix_end;
    logic              pre_ok;
    logic [LW-1:0]     lo;
    logic [LW-1:0]     hi;
    logic              rd_en;
    logic              found;
    logic              fail;
    logic [LW-1:0]     start_found;
    logic              wr_en;
    logic [SW-1:0]     wr_addr;

    // Usable limit, clamped to the segment
    assign limit = (LW'(r_usable) > SLOTS_L) ? SLOTS_L : LW'(r_usable);

    // Range check before scanning
    assign fix_end = {1'b0, r_off[ADDR_W-1:0]} + EW'(r_size);
    always_comb begin
        if (r_size == '0) begin
            pre_ok = 1'b0;
        end else if (r_func == FUNC_FIXED) begin
            pre_ok = !r_off[ADDR_W] && (fix_end <= EW'(limit));
        end else begin
            pre_ok = (LW'(r_size) <= limit);
        end
    end

    assign lo = (r_func == FUNC_FIXED) ? r_off[LW-1:0] : '0;
    assign hi = (r_func == FUNC_FIXED) ? fix_end[LW-1:0] : limit;

    // Scan results on the returned flag
    assign rd_en = i_cmd.scan && (r_rd < hi);
    assign found = r_ck_valid && !r_rdata && ((r_run + SIZE_W'(1)) == r_size);
    assign fail  = r_ck_valid && !found &&
                   ((r_rdata && (r_func == FUNC_FIXED)) || ((r_ck + LW'(1)) == hi));
    assign start_found = r_ck + LW'(1) - LW'(r_size);

    // Write port: clear pass or marking
    assign wr_en   = i_cmd.clr || i_cmd.mark;
    assign wr_addr = i_cmd.clr ? r_clr : r_mark;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= i_cmd.mark;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rdata <= mem[r_rd[SW-1:0]];
        end
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base   <= BASE_RST;
            r_usable <= USABLE_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_BASE:   r_base   <= i_cfg_data[ADDR_W-1:0];
                CFG_USABLE: r_usable <= i_cfg_data[USABLE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Latch the request; offset keeps the borrow in its top bit
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_func <= i_func;
            r_size <= i_size;
            r_off  <= {1'b0, i_address} - {1'b0, r_base};
        end
    end

    // Clear pass counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr <= '0;
        end else if (i_cmd.clr) begin
            r_clr <= r_clr + SW'(1);
        end
    end

    // Advance the scan, one flag a cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ck_valid <= 1'b0;
        end else if (i_cmd.scan_start) begin
            r_ck_valid <= 1'b0;
        end else if (i_cmd.scan) begin
            r_ck_valid <= rd_en;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_start) begin
            r_rd  <= lo;
            r_run <= '0;
        end else if (i_cmd.scan) begin
            if (rd_en) begin
                r_rd <= r_rd + LW'(1);
                r_ck <= r_rd;
            end
            if (r_ck_valid) begin
                r_run <= r_rdata ? '0 : r_run + SIZE_W'(1);
            end
        end
    end

    // Hold the start of the run and walk it while marking
    always_ff @(posedge i_clk) begin
        if (i_cmd.scan && found) begin
            r_start <= start_found[SW-1:0];
            r_mark  <= start_found[SW-1:0];
            r_left  <= r_size;
        end else if (i_cmd.mark) begin
            r_mark <= r_mark + SW'(1);
            r_left <= r_left - SIZE_W'(1);
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.resp_ok || i_cmd.resp_fail) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.resp_ok || i_cmd.resp_fail) begin
            r_out_ok   <= i_cmd.resp_ok;
            r_out_addr <= i_cmd.resp_ok ? r_base + ADDR_W'(r_start) : '0;
        end
    end

    assign o_status.clr_last  = (r_clr == SW'(SLOTS - 1));
    assign o_status.pre_ok    = pre_ok;
    assign o_status.found     = found;
    assign o_status.fail      = fail;
    assign o_status.mark_last = (r_left == SIZE_W'(1));
    assign o_status.out_free  = !r_out_valid || !i_out_stall;

    assign o_out_valid           = r_out_valid;
    assign o_out_ok              = r_out_ok;
    assign o_out_granted_address = r_out_addr;

endmodule

// ----- rtl/first_fit_slot_allocator.sv -----
// An accepted request is range checked, then scanned and, if a run is found, marked before
//   the result word; the flag memory is read one slot a cycle in the scan and written one
//   a cycle when marking. One request at a time; the next is taken the cycle after the result
//   word is loaded.
// Reset: synchronous, active low; a clearing pass frees every slot, and requests are
//   stalled until it ends.
module first_fit_slot_allocator #(
    parameter int SLOTS = ffsa_pkg::SLOTS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [ffsa_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [ffsa_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [ffsa_pkg::FUNC_W-1:0]     i_func,
    input  logic [ffsa_pkg::SIZE_W-1:0]     i_size,
    input  logic [ffsa_pkg::ADDR_W-1:0]     i_address,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic                            o_ok,
    output logic [ffsa_pkg::ADDR_W-1:0]     o_granted_address
);
    import ffsa_pkg::*;

    t_cmd    cmd;
    t_status status;

    // Sequencer
    ffsa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_status   (status),
        .o_cmd      (cmd),
        .o_in_stall (o_in_stall)
    );

    // Flag memory, scan and result register
    ffsa_dp #(
        .SLOTS (SLOTS)
    ) u_dp (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_cfg_we              (i_cfg_we),
        .i_cfg_index           (i_cfg_index),
        .i_cfg_data            (i_cfg_data),
        .i_func                (i_func),
        .i_size                (i_size),
        .i_address             (i_address),
        .i_out_stall           (i_out_stall),
        .i_cmd                 (cmd),
        .o_status              (status),
        .o_out_valid           (o_out_valid),
        .o_out_ok              (o_ok),
        .o_out_granted_address (o_granted_address)
    );

endmodule

// ----- rtl/ffsa_chk.sv -----
`include "first_fit_slot_allocator_macros.svh"

module ffsa_chk (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_in_valid,
    input logic                            o_in_stall,
    input logic                            o_out_valid,
    input logic                            i_out_stall,
    input logic                            o_ok,
    input logic [ffsa_pkg::ADDR_W-1:0]     o_granted_address
);
    import ffsa_pkg::*;

    // A refused request carries a zero address
    `FFSA_ASSERT_NOW(a_fail_zero, i_clk, i_rst_n, o_out_valid && !o_ok, o_granted_address == '0)

    // One request at a time: the input stalls right after an accept
    `FFSA_ASSERT_NEXT(a_one_at_a_time, i_clk, i_rst_n, i_in_valid && !o_in_stall, o_in_stall)

    // A stalled result word stays valid and unchanged
    `FFSA_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_ok) && $stable(o_granted_address))

    // No result word in the cycle after a reset edge
    `FFSA_ASSERT_NEXT(a_reset_empty, i_clk, 1'b1, !i_rst_n, !o_out_valid)

endmodule

bind first_fit_slot_allocator ffsa_chk u_ffsa_chk (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_in_valid        (i_in_valid),
    .o_in_stall        (o_in_stall),
    .o_out_valid       (o_out_valid),
    .i_out_stall       (i_out_stall),
    .o_ok              (o_ok),
    .o_granted_address (o_granted_address)
);
